[rtl/sar_pkg.sv]
// Shared types and codes for the scroll address register unit.
// No dependencies; used by every module under rtl.
package sar_pkg;

  localparam int AddrW = 15;
  localparam int FetchW = 14;

  // Action codes carried by the input word.
  localparam logic [2:0] ACT_CPU_WRITE = 3'd0;
  localparam logic [2:0] ACT_CPU_READ  = 3'd1;
  localparam logic [2:0] ACT_COARSE_X  = 3'd2;
  localparam logic [2:0] ACT_Y_STEP    = 3'd3;
  localparam logic [2:0] ACT_COPY_H    = 3'd4;
  localparam logic [2:0] ACT_COPY_V    = 3'd5;

  // CPU register indexes.
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDRESS = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [4:0] COARSE_LAST = 5'd31;
  localparam logic [4:0] ROW_LAST    = 5'd29;
  localparam logic [2:0] FINE_LAST   = 3'd7;

  typedef struct packed {
    logic [AddrW-1:0] cur;
    logic [AddrW-1:0] tmp;
    logic [2:0]       fine_x;
    logic             toggle;
    logic             inc_row;
  } sar_regs_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] reg_sel;
    logic [7:0] data;
  } sar_item_t;

endpackage

[rtl/sar_update.sv]
// Next-state logic of the scroll address registers for one event.
// Depends on sar_pkg.
module sar_update
  import sar_pkg::*;
(
  input  sar_regs_t regs,
  input  sar_item_t item,
  output sar_regs_t regs_next
);

  logic [13:0] bumped_low;
  logic [4:0]  row_now;

  always_comb begin
    bumped_low = regs.cur[13:0] + (regs.inc_row ? 14'd32 : 14'd1);
    row_now    = regs.cur[9:5];
    regs_next  = regs;
    case (item.action)
      ACT_CPU_WRITE: begin
        case (item.reg_sel)
          REG_CONTROL: begin
            regs_next.tmp[11:10] = item.data[1:0];
            regs_next.inc_row    = item.data[2];
          end
          REG_SCROLL: begin
            if (!regs.toggle) begin
              regs_next.fine_x   = item.data[2:0];
              regs_next.tmp[4:0] = item.data[7:3];
            end else begin
              regs_next.tmp[14:12] = item.data[2:0];
              regs_next.tmp[9:5]   = item.data[7:3];
            end
            regs_next.toggle = ~regs.toggle;
          end
          REG_ADDRESS: begin
            if (!regs.toggle) begin
              regs_next.tmp[14]   = 1'b0;
              regs_next.tmp[13:8] = item.data[5:0];
            end else begin
              regs_next.tmp[7:0] = item.data;
              regs_next.cur      = {regs.tmp[14:8], item.data};
            end
            regs_next.toggle = ~regs.toggle;
          end
          REG_DATA: begin
            regs_next.cur[13:0] = bumped_low;
          end
          default: begin
          end
        endcase
      end
      ACT_CPU_READ: begin
        if (item.reg_sel == REG_STATUS) begin
          regs_next.toggle = 1'b0;
        end else if (item.reg_sel == REG_DATA) begin
          regs_next.cur[13:0] = bumped_low;
        end
      end
      ACT_COARSE_X: begin
        if (regs.cur[4:0] == COARSE_LAST) begin
          regs_next.cur[4:0] = 5'd0;
          regs_next.cur[10]  = ~regs.cur[10];
        end else begin
          regs_next.cur[4:0] = regs.cur[4:0] + 5'd1;
        end
      end
      ACT_Y_STEP: begin
        if (regs.cur[14:12] != FINE_LAST) begin
          regs_next.cur[14:12] = regs.cur[14:12] + 3'd1;
        end else begin
          regs_next.cur[14:12] = 3'd0;
          if (row_now == ROW_LAST) begin
            regs_next.cur[9:5] = 5'd0;
            regs_next.cur[11]  = ~regs.cur[11];
          end else if (row_now == COARSE_LAST) begin
            regs_next.cur[9:5] = 5'd0;
          end else begin
            regs_next.cur[9:5] = row_now + 5'd1;
          end
        end
      end
      ACT_COPY_H: begin
        regs_next.cur[10]  = regs.tmp[10];
        regs_next.cur[4:0] = regs.tmp[4:0];
      end
      ACT_COPY_V: begin
        regs_next.cur[14:11] = regs.tmp[14:11];
        regs_next.cur[9:5]   = regs.tmp[9:5];
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/sar_fetch.sv]
// Tile and attribute fetch address decode from the current address.
// Depends on sar_pkg.
module sar_fetch
  import sar_pkg::*;
(
  input  logic [AddrW-1:0]  cur,
  output logic [FetchW-1:0] tile_addr,
  output logic [FetchW-1:0] attr_addr
);

  // Nametable base at 0x2000; attribute table sits at offset 0x3C0.
  assign tile_addr = {2'b10, cur[11:0]};
  assign attr_addr = {2'b10, cur[11:10], 4'b1111, cur[9:7], cur[4:2]};

endmodule

[rtl/scroll_address_register_unit.sv]
// Top level of the scroll address register unit.
// Depends on sar_pkg, sar_update and sar_fetch.
//
// Usage:
// The input channel (in_valid / in_stall) carries one event word per
// cycle while in_stall is low: a CPU register write or read, or a render
// event (coarse X step, Y step, horizontal or vertical copy from the
// temporary address). The output channel (out_valid / out_stall) returns
// one result word per event, showing the registers after that event: the
// current address, the tile and attribute fetch addresses, fine X and the
// write toggle. An accepted word goes into an input register; the register
// update and the fetch address decode run in a single short combinational
// pass from there, and the result lands in the output register, where
// out_valid rises. While out_stall stays low the unit sustains one word
// per cycle. The input register keeps accepting while a result waits, so
// in_stall only rises when both stages are full and the receiver holds
// out_stall high.
// Reset clears every address register, fine X, the toggle and the
// increment mode (increment by one), and empties both stages.
module scroll_address_register_unit
  import sar_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        action,
  input  logic [2:0]        reg_select,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AddrW-1:0]  current_address,
  output logic [FetchW-1:0] tile_fetch_address,
  output logic [FetchW-1:0] attribute_fetch_address,
  output logic [2:0]        fine_x_scroll,
  output logic              second_write_pending
);

  // Input stage holding one event word.
  logic      s1_valid;
  sar_item_t s1_item;

  // Architectural registers and their next value for the held event.
  sar_regs_t regs;
  sar_regs_t regs_next;

  logic [FetchW-1:0] tile_next;
  logic [FetchW-1:0] attr_next;

  logic advance;
  logic in_take;

  // The held event commits when the output register is free or being drained.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  sar_update u_update (
    .regs      (regs),
    .item      (s1_item),
    .regs_next (regs_next)
  );

  sar_fetch u_fetch (
    .cur       (regs_next.cur),
    .tile_addr (tile_next),
    .attr_addr (attr_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.action  <= action;
      s1_item.reg_sel <= reg_select;
      s1_item.data    <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (advance) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current_address         <= regs_next.cur;
      tile_fetch_address      <= tile_next;
      attribute_fetch_address <= attr_next;
      fine_x_scroll           <= regs_next.fine_x;
      second_write_pending    <= regs_next.toggle;
    end
  end

  // A committed event always leaves a result behind.
  assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("committed event produced no result");

  // The shown current address, fine X and toggle always match the committed register state.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_address == regs.cur && fine_x_scroll == regs.fine_x
                   && second_write_pending == regs.toggle))
    else $error("result word disagrees with register state");

  // A held event waits unchanged until it commits.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_item))
    else $error("held event lost or changed while stalled");

  // Stall only rises with a full input stage.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid)
    else $error("input stalled with empty input stage");

endmodule
